FILE: design/nbos_pkg.sv
// Package for the nearest box owner select block: widths, mode and status codes.
// Used by every module in the design folder; depends on nothing.
package nbos_pkg;

    localparam int MaxBoxes  = 64;
    localparam int IdxBits   = $clog2(MaxBoxes);
    localparam int CntBits   = $clog2(MaxBoxes + 1);
    localparam int CoordBits = 20;
    localparam int IdBits    = 32;
    localparam int VolBits   = 64;
    localparam int DistBits  = 2 * (CoordBits + 1) + 2;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    localparam logic [1:0] STATUS_DONE       = 2'd0;
    localparam logic [1:0] STATUS_FULL       = 2'd1;
    localparam logic [1:0] STATUS_INELIGIBLE = 2'd2;

    localparam logic [1:0] KIND_GAUSSIAN = 2'd0;
    localparam logic [1:0] KIND_HYBRID   = 2'd1;

    localparam logic CFG_MAX_DISTANCE = 1'b0;
    localparam logic CFG_REQUIRE      = 1'b1;

    typedef struct packed {
        logic [IdBits-1:0]    id;
        logic [VolBits-1:0]   vol;
        logic [CoordBits-1:0] lo_x;
        logic [CoordBits-1:0] lo_y;
        logic [CoordBits-1:0] lo_z;
        logic [CoordBits-1:0] hi_x;
        logic [CoordBits-1:0] hi_y;
        logic [CoordBits-1:0] hi_z;
    } box_t;

    // Clamp an extent to zero when the box is inverted on that axis.
    function automatic logic [CoordBits:0] extent(input logic [CoordBits-1:0] lo,
                                                  input logic [CoordBits-1:0] hi);
        logic signed [CoordBits:0] d;
        d = $signed({hi[CoordBits-1], hi}) - $signed({lo[CoordBits-1], lo});
        extent = d[CoordBits] ? '0 : d;
    endfunction

endpackage

FILE: design/nearest_box_owner_select_core.sv
// Top level of the nearest box owner select block: sequencer, counters and result register.
// Depends on nbos_pkg, nbos_box_ram and nbos_dist_unit.
//
//  channel | direction | payload
//  s_axis  | in        | tdata: mode, entity_id, kind, box min xyz, box max xyz, point xyz
//  m_axis  | out       | tdata: status, owner_valid, owner_id, inside_box, assigned, unassigned
//  cfg     | in        | cfg_index 1 bit, cfg_data 20 bits
//
// A load builds the volume with one shared 21 by 21 multiplier over the states S_VOL1,
// S_VOL2 and S_VOL3; a query takes, for each stored box, one read of the box memory,
// three axis steps through the distance unit and a compare.
// Reset clears counters, box count and handshake state; the table needs no sweep.
// The input is not ready while an item is in work or its result waits on m_axis.
module nearest_box_owner_select_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[1:0], entity_id[33:2], kind[35:34], min x,y,z, max x,y,z, point x,y,z [215:36]
    input  logic [215:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], owner_valid[2], owner_id[34:3], inside_box[35], assigned[67:36],
    // unassigned[99:68]
    output logic [103:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [19:0]  cfg_data
);
    localparam int CB = nbos_pkg::CoordBits;
    localparam int VB = nbos_pkg::VolBits;

    typedef enum logic [3:0] {
        S_IDLE, S_VOL1, S_VOL2, S_VOL3, S_STORE, S_RD, S_AX0, S_AX1, S_AX2, S_CMP, S_DONE,
        S_OUT
    } state_t;

    state_t state_reg;
    logic [215:0] in_reg;
    logic [CB-1:0] maxd_reg;
    logic req_reg;
    logic [nbos_pkg::CntBits-1:0] count_reg, idx_reg;
    logic [31:0] asg_reg, una_reg;
    logic [31:0] asg_next, una_next;
    logic [VB-1:0] vol_reg;
    logic [2*CB+1:0] part_reg;
    logic have_reg, bin_reg;
    logic [nbos_pkg::DistBits-1:0] bd_reg, lim_reg;
    logic [VB-1:0] bv_reg;
    logic [31:0] bid_reg;
    logic [1:0] status_reg;
    logic [103:0] out_reg;
    logic [103:0] out_next;

    nbos_pkg::box_t wbox, rbox;
    logic we;
    logic [CB-1:0] p_sel, lo_sel, hi_sel;
    logic d_start, d_step, c_in;
    logic [nbos_pkg::DistBits-1:0] d2;
    logic better;
    logic [CB:0] ex, ey, ez;
    logic [CB:0] mul_a, mul_b;
    logic [2*CB+1:0] prod;
    logic [2*CB-1:0] lim_sq;

    wire [1:0]  in_mode = in_reg[1:0];
    wire [31:0] in_id   = in_reg[33:2];
    wire [1:0]  in_kind = in_reg[35:34];
    wire [CB-1:0] mnx = in_reg[55:36],  mny = in_reg[75:56],  mnz = in_reg[95:76];
    wire [CB-1:0] mxx = in_reg[115:96], mxy = in_reg[135:116], mxz = in_reg[155:136];
    wire [CB-1:0] ptx = in_reg[175:156], pty = in_reg[195:176], ptz = in_reg[215:196];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = out_reg;

    // The area product x*y is split into two 21-bit halves so that one multiplier serves
    // every step of the volume.
    always_comb
    begin
        ex = nbos_pkg::extent(mnx, mxx);
        ey = nbos_pkg::extent(mny, mxy);
        ez = nbos_pkg::extent(mnz, mxz);
        case (state_reg)
            S_VOL1:
            begin
                mul_a = ex;
                mul_b = ey;
            end
            S_VOL2:
            begin
                mul_a = vol_reg[CB:0];
                mul_b = ez;
            end
            default:
            begin
                mul_a = vol_reg[2*CB+1:CB+1];
                mul_b = ez;
            end
        endcase
        prod   = mul_a * mul_b;
        lim_sq = maxd_reg * maxd_reg;
    end

    always_comb
    begin
        wbox.id   = in_id;
        wbox.vol  = vol_reg;
        wbox.lo_x = mnx; wbox.lo_y = mny; wbox.lo_z = mnz;
        wbox.hi_x = mxx; wbox.hi_y = mxy; wbox.hi_z = mxz;
        we = (state_reg == S_STORE);
    end

    nbos_box_ram u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[nbos_pkg::IdxBits-1:0]),
        .wdata (wbox),
        .raddr (idx_reg[nbos_pkg::IdxBits-1:0]),
        .rdata (rbox)
    );

    always_comb
    begin
        case (state_reg)
            S_AX1:
            begin
                p_sel = pty; lo_sel = rbox.lo_y; hi_sel = rbox.hi_y;
            end
            S_AX2:
            begin
                p_sel = ptz; lo_sel = rbox.lo_z; hi_sel = rbox.hi_z;
            end
            default:
            begin
                p_sel = ptx; lo_sel = rbox.lo_x; hi_sel = rbox.hi_x;
            end
        endcase
        d_start = (state_reg == S_RD);
        d_step  = (state_reg == S_AX0) || (state_reg == S_AX1) || (state_reg == S_AX2);
    end

    nbos_dist_unit u_dist (
        .clk       (clk),
        .start     (d_start),
        .step      (d_step),
        .p         (p_sel),
        .lo        (lo_sel),
        .hi        (hi_sel),
        .d2        (d2),
        .contained (c_in)
    );

    always_comb
    begin
        if (!have_reg)
            better = 1'b1;
        else if (c_in != bin_reg)
            better = c_in;
        else if (!c_in && d2 != bd_reg)
            better = d2 < bd_reg;
        else if (rbox.vol != bv_reg)
            better = rbox.vol < bv_reg;
        else
            better = rbox.id < bid_reg;
    end

    always_comb
    begin
        out_next      = '0;
        out_next[1:0] = status_reg;
        asg_next      = asg_reg;
        una_next      = una_reg;
        case (in_mode)
            nbos_pkg::MODE_CLEAR:
            begin
                asg_next = '0;
                una_next = '0;
            end
            nbos_pkg::MODE_QUERY:
            begin
                if (have_reg)
                begin
                    out_next[2]    = 1'b1;
                    out_next[34:3] = bid_reg;
                    out_next[35]   = bin_reg;
                    if (asg_reg != '1)
                        asg_next = asg_reg + 1'b1;
                end
                else if (una_reg != '1)
                    una_next = una_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
        out_next[67:36] = asg_next;
        out_next[99:68] = una_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            maxd_reg  <= '0;
            req_reg   <= 1'b0;
            count_reg <= '0;
            asg_reg   <= '0;
            una_reg   <= '0;
            idx_reg   <= '0;
            have_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        case (cfg_index)
                            nbos_pkg::CFG_MAX_DISTANCE: maxd_reg <= cfg_data;
                            default:                    req_reg  <= cfg_data[0];
                        endcase
                    end
                    if (s_axis_tvalid)
                    begin
                        in_reg     <= s_axis_tdata;
                        status_reg <= nbos_pkg::STATUS_DONE;
                        have_reg   <= 1'b0;
                        idx_reg    <= '0;
                        lim_reg    <= nbos_pkg::DistBits'(lim_sq);
                        case (nbos_pkg::mode_t'(s_axis_tdata[1:0]))
                            nbos_pkg::MODE_LOAD:  state_reg <= S_VOL1;
                            nbos_pkg::MODE_QUERY: state_reg <= S_RD;
                            default:              state_reg <= S_DONE;
                        endcase
                    end
                end
                S_VOL1:
                begin
                    vol_reg <= VB'(prod);
                    if (req_reg && in_kind != nbos_pkg::KIND_GAUSSIAN
                        && in_kind != nbos_pkg::KIND_HYBRID)
                    begin
                        status_reg <= nbos_pkg::STATUS_INELIGIBLE;
                        state_reg  <= S_DONE;
                    end
                    else if (count_reg >= nbos_pkg::CntBits'(nbos_pkg::MaxBoxes))
                    begin
                        status_reg <= nbos_pkg::STATUS_FULL;
                        state_reg  <= S_DONE;
                    end
                    else
                        state_reg <= S_VOL2;
                end
                S_VOL2:
                begin
                    part_reg  <= prod;
                    state_reg <= S_VOL3;
                end
                S_VOL3:
                begin
                    vol_reg   <= (VB'(prod) << (CB + 1)) + VB'(part_reg);
                    state_reg <= S_STORE;
                end
                S_STORE:
                begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= S_DONE;
                end
                S_RD:
                    state_reg <= (idx_reg >= count_reg) ? S_DONE : S_AX0;
                S_AX0: state_reg <= S_AX1;
                S_AX1: state_reg <= S_AX2;
                S_AX2: state_reg <= S_CMP;
                S_CMP:
                begin
                    if (d2 <= lim_reg && better)
                    begin
                        have_reg <= 1'b1;
                        bin_reg  <= c_in;
                        bd_reg   <= d2;
                        bv_reg   <= rbox.vol;
                        bid_reg  <= rbox.id;
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_RD;
                end
                S_DONE:
                begin
                    out_reg <= out_next;
                    asg_reg <= asg_next;
                    una_reg <= una_next;
                    if (in_mode == nbos_pkg::MODE_CLEAR)
                        count_reg <= '0;
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (m_axis_tready)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: design/nbos_box_ram.sv
// Box table memory: one write port and one registered read port.
// Depends on nbos_pkg for the entry type and depth.
module nbos_box_ram (
    input  logic                           clk,
    input  logic                           we,
    input  logic [nbos_pkg::IdxBits-1:0]   waddr,
    input  nbos_pkg::box_t                 wdata,
    input  logic [nbos_pkg::IdxBits-1:0]   raddr,
    output nbos_pkg::box_t                 rdata
);
    nbos_pkg::box_t mem [nbos_pkg::MaxBoxes];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/nbos_dist_unit.sv
// Shared distance unit: squared clamp distance of a point to one box, one axis a cycle.
// Depends on nbos_pkg for coordinate and distance widths.
module nbos_dist_unit (
    input  logic                              clk,
    input  logic                              start,
    input  logic                              step,
    input  logic [nbos_pkg::CoordBits-1:0]    p,
    input  logic [nbos_pkg::CoordBits-1:0]    lo,
    input  logic [nbos_pkg::CoordBits-1:0]    hi,
    output logic [nbos_pkg::DistBits-1:0]     d2,
    output logic                              contained
);
    logic signed [nbos_pkg::CoordBits-1:0] ps, los, his, c;
    logic signed [nbos_pkg::CoordBits:0]   d;
    logic [nbos_pkg::CoordBits:0]          ad;
    logic [2*nbos_pkg::CoordBits+1:0]      sq;
    logic [nbos_pkg::DistBits-1:0]         d2_reg;
    logic                                  in_reg;

    always_comb
    begin
        ps  = $signed(p);
        los = $signed(lo);
        his = $signed(hi);
        c   = (ps < los) ? los : ps;
        if (c > his)
        begin
            c = his;
        end
        d  = $signed({ps[nbos_pkg::CoordBits-1], ps}) - $signed({c[nbos_pkg::CoordBits-1], c});
        ad = d[nbos_pkg::CoordBits] ? $unsigned(-d) : $unsigned(d);
        sq = ad * ad;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d2_reg <= '0;
            in_reg <= 1'b1;
        end
        else if (step)
        begin
            d2_reg <= d2_reg + nbos_pkg::DistBits'(sq);
            in_reg <= in_reg & ~((ps < los) | (ps > his));
        end
    end

    assign d2        = d2_reg;
    assign contained = in_reg;
endmodule

FILE: tb/testbench.sv
// Self-checking testbench for nearest_box_owner_select_core: drives loads, clears and
// point queries over the stream ports and checks every result against its own predictor.
// Depends on nbos_pkg and the design folder only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  status;
        logic        owner_valid;
        logic [31:0] owner_id;
        logic        inside_box;
        logic [31:0] assigned;
        logic [31:0] unassigned;
    } owner_result_t;

    // Predictor of the owner table plus the queue of results still to arrive.
    class owner_scoreboard;
        logic signed [19:0] lo [nbos_pkg::MaxBoxes][3];
        logic signed [19:0] hi [nbos_pkg::MaxBoxes][3];
        logic [31:0] ids [nbos_pkg::MaxBoxes];
        logic [63:0] vols [nbos_pkg::MaxBoxes];
        int          count;
        logic [31:0] n_assigned = '0, n_unassigned = '0;
        logic [19:0] max_dist;
        logic        require_gauss;
        owner_result_t pending[$];
        int errors, loads, queries, owned, inside_hits, fulls, skips;

        function void note_config(logic idx, logic [19:0] data);
            if (idx == nbos_pkg::CFG_MAX_DISTANCE) max_dist = data;
            else require_gauss = data[0];
        endfunction

        function void note_item(logic [215:0] d);
            owner_result_t r;
            logic [1:0] mode, kind;
            logic signed [19:0] p [3];
            logic signed [20:0] ext, c;
            logic [63:0] vol, d2, best_d, best_v, lim;
            logic [31:0] best_id;
            logic have, best_in, c_in, better;
            mode = d[1:0];
            kind = d[35:34];
            r = '{2'd0, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0};
            if (mode == nbos_pkg::MODE_CLEAR) begin
                count = 0;
                n_assigned = 0;
                n_unassigned = 0;
            end else if (mode == nbos_pkg::MODE_LOAD) begin
                loads++;
                if (require_gauss && kind != nbos_pkg::KIND_GAUSSIAN
                    && kind != nbos_pkg::KIND_HYBRID) begin
                    r.status = nbos_pkg::STATUS_INELIGIBLE;
                    skips++;
                end else if (count >= nbos_pkg::MaxBoxes) begin
                    r.status = nbos_pkg::STATUS_FULL;
                    fulls++;
                end else begin
                    vol = 1;
                    for (int a = 0; a < 3; a++) begin
                        lo[count][a] = d[36 + 20*a +: 20];
                        hi[count][a] = d[96 + 20*a +: 20];
                        ext = hi[count][a] - lo[count][a];
                        vol = vol * (ext > 0 ? 64'(ext) : 64'd0);
                    end
                    ids[count] = d[33:2];
                    vols[count] = vol;
                    count++;
                end
            end else if (mode == nbos_pkg::MODE_QUERY) begin
                queries++;
                for (int a = 0; a < 3; a++) p[a] = d[156 + 20*a +: 20];
                lim = 64'(max_dist) * 64'(max_dist);
                have = 0; best_in = 0; best_d = 0; best_v = 0; best_id = 0;
                for (int i = 0; i < count; i++) begin
                    d2 = 0;
                    c_in = 1;
                    for (int a = 0; a < 3; a++) begin
                        c = (p[a] < lo[i][a]) ? lo[i][a] : p[a];
                        if (c > hi[i][a]) c = hi[i][a];
                        c = p[a] - c;
                        if (c < 0) c = -c;
                        d2 += 64'(c) * 64'(c);
                        if (p[a] < lo[i][a] || p[a] > hi[i][a]) c_in = 0;
                    end
                    if (d2 <= lim) begin
                        if (!have) better = 1;
                        else if (c_in != best_in) better = c_in;
                        else if (!c_in && d2 != best_d) better = d2 < best_d;
                        else if (vols[i] != best_v) better = vols[i] < best_v;
                        else better = ids[i] < best_id;
                        if (better) begin
                            have = 1; best_in = c_in; best_d = d2;
                            best_v = vols[i]; best_id = ids[i];
                        end
                    end
                end
                if (have) begin
                    r.owner_valid = 1;
                    r.owner_id = best_id;
                    r.inside_box = best_in;
                    owned++;
                    if (best_in) inside_hits++;
                    if (n_assigned != '1) n_assigned++;
                end else if (n_unassigned != '1) n_unassigned++;
            end
            r.assigned = n_assigned;
            r.unassigned = n_unassigned;
            pending = {pending, r};
        endfunction

        function void check_result(logic [103:0] t);
            owner_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, t);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (t[1:0] !== e.status) begin
                $display("%0t: status exp %0d got %0d", $time, e.status, t[1:0]);
                errors++;
            end
            if (t[2] !== e.owner_valid) begin
                $display("%0t: owner_valid exp %0d got %0d", $time, e.owner_valid, t[2]);
                errors++;
            end
            if (t[34:3] !== e.owner_id) begin
                $display("%0t: owner_id exp %h got %h", $time, e.owner_id, t[34:3]);
                errors++;
            end
            if (t[35] !== e.inside_box) begin
                $display("%0t: inside_box exp %0d got %0d", $time, e.inside_box, t[35]);
                errors++;
            end
            if (t[67:36] !== e.assigned) begin
                $display("%0t: assigned exp %0d got %0d", $time, e.assigned, t[67:36]);
                errors++;
            end
            if (t[99:68] !== e.unassigned) begin
                $display("%0t: unassigned exp %0d got %0d", $time, e.unassigned, t[99:68]);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0, rst_n = 0;
    logic s_axis_tvalid = 0, s_axis_tready, m_axis_tvalid, m_axis_tready = 0;
    logic [215:0] s_axis_tdata = '0;
    logic [103:0] m_axis_tdata;
    logic cfg_valid = 0, cfg_ready, cfg_index = 0;
    logic [19:0] cfg_data = '0;
    logic quiet_tail = 0;
    int idle_cycles = 0;
    owner_scoreboard board;

    always #5 clk = ~clk;

    nearest_box_owner_select_core dut (.*);

    // Result side: random stall bursts, checks at each accepted transaction.
    initial begin
        int stall;
        forever begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
            if (stall > 0) begin
                stall--;
                m_axis_tready <= 0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(0, 4);
                m_axis_tready <= 0;
            end else m_axis_tready <= 1;
        end
    end

    // Watchdog: must outlast a query over a full table plus the stalls on the result side.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("FAIL");
            $finish;
        end
    end

    // The block is never ready in the cycle after an input transaction, so the extra
    // edge after dropping tvalid costs nothing.
    task automatic send_item(logic [215:0] d);
        if (!quiet_tail && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 5)) @(posedge clk);
        s_axis_tvalid <= 1;
        s_axis_tdata <= d;
        do @(posedge clk); while (!s_axis_tready);
        board.note_item(d);
        s_axis_tvalid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [19:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        board.note_config(idx, data);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    function automatic logic [215:0] item(logic [1:0] mode, logic [31:0] id,
                                          logic [1:0] kind, logic [179:0] coords);
        return {coords, kind, id, mode};
    endfunction

    // Coordinates near a small region so boxes overlap and queries hit.
    function automatic logic [19:0] near(int spread);
        return 20'($signed($urandom_range(0, 2*spread)) - spread);
    endfunction

    function automatic logic [179:0] rand_box(bit wide);
        logic [19:0] a, b;
        logic [179:0] c;
        c = '0;
        for (int k = 0; k < 3; k++) begin
            a = wide ? 20'($urandom) : near(4000);
            b = ($urandom_range(0, 9) == 0) ? a - 20'($urandom_range(1, 500))
                                            : a + 20'($urandom_range(0, 3000));
            if (wide && $urandom_range(0, 1)) b = 20'($urandom);
            c[20*k +: 20] = a;
            c[60 + 20*k +: 20] = b;
        end
        return c;
    endfunction

    function automatic logic [179:0] rand_point(bit wide);
        logic [179:0] c;
        c = '0;
        for (int k = 0; k < 3; k++) c[120 + 20*k +: 20] = wide ? 20'($urandom) : near(6000);
        return c;
    endfunction

    initial begin
        logic [179:0] c;
        int r;
        board = new();
        board.max_dist = 0;
        board.require_gauss = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty table, extreme boxes, face contact, ineligible kinds, mode 3.
        send_item(item(nbos_pkg::MODE_QUERY, 0, 2'd0, '0));
        write_reg(nbos_pkg::CFG_MAX_DISTANCE, 20'hFFFFF);
        c = '0;
        c[59:0] = {3{20'h80000}};
        c[119:60] = {3{20'h7FFFF}};
        send_item(item(nbos_pkg::MODE_LOAD, 32'hFFFFFFFF, 2'd2, c));
        send_item(item(nbos_pkg::MODE_LOAD, 32'h0, 2'd1, {60'd0, {3{20'd100}}, {3{20'd0}}}));
        send_item(item(nbos_pkg::MODE_LOAD, 32'h5, 2'd0, {60'd0, {3{20'd100}}, {3{20'd0}}}));
        send_item(item(nbos_pkg::MODE_QUERY, 0, 2'd0, {{3{20'd100}}, 120'd0}));
        send_item(item(nbos_pkg::MODE_QUERY, 0, 2'd0, {{3{20'h7FFFF}}, 120'd0}));
        send_item(item(nbos_pkg::MODE_QUERY, 0, 2'd0, {{3{20'h80000}}, 120'd0}));
        // Inverted box
        send_item(item(nbos_pkg::MODE_LOAD, 32'h77, 2'd3, {60'd0, {3{20'd10}}, {3{20'd50}}}));
        send_item(item(nbos_pkg::MODE_QUERY, 0, 2'd0, {{3{20'd30}}, 120'd0}));
        send_item(item(nbos_pkg::MODE_NONE, 32'hFFFFFFFF, 2'd3, '1));
        send_item(item(nbos_pkg::MODE_CLEAR, 32'hFFFFFFFF, 2'd3, '1));
        send_item(item(nbos_pkg::MODE_QUERY, 0, 2'd0, '1));
        drain();
        write_reg(nbos_pkg::CFG_REQUIRE, 20'hFFFFF);
        write_reg(nbos_pkg::CFG_MAX_DISTANCE, 20'd0);
        for (int k = 0; k < 4; k++)
            send_item(item(nbos_pkg::MODE_LOAD, 32'h100 + k, 2'(k), rand_box(0)));
        send_item(item(nbos_pkg::MODE_QUERY, 0, 2'd0, rand_point(0)));
        // Fill the table to overflow.
        for (int k = 0; k < 66; k++)
            send_item(item(nbos_pkg::MODE_LOAD, $urandom, 2'($urandom_range(0, 1)),
                           rand_box(k[0])));
        send_item(item(nbos_pkg::MODE_QUERY, 0, 2'd0, rand_point(0)));
        drain();

        // Random phases with differing settings; the last phase has no idling.
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(nbos_pkg::CFG_MAX_DISTANCE, ph == 0 ? 20'd0 : ph == 1 ? 20'hFFFFF
                                        : 20'($urandom_range(0, 20000)));
            write_reg(nbos_pkg::CFG_REQUIRE, 20'($urandom));
            if (ph == 5) quiet_tail = 1;
            send_item(item(nbos_pkg::MODE_CLEAR, $urandom, 2'($urandom), '0));
            for (int k = 0; k < 160; k++) begin
                r = $urandom_range(0, 99);
                // Mostly small tables so queries stay short.
                if (board.count > 12 && r < 40) r = 50;
                if (r < 40)
                    send_item(item(nbos_pkg::MODE_LOAD,
                                   $urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : $urandom,
                                   2'($urandom), rand_box($urandom_range(0, 7) == 0)));
                else if (r < 93)
                    send_item(item(nbos_pkg::MODE_QUERY, $urandom, 2'($urandom),
                                   {rand_point($urandom_range(0, 7) == 0)} | 180'($urandom)));
                else if (r < 96)
                    send_item(item(nbos_pkg::MODE_CLEAR, $urandom, 2'($urandom), '1));
                else
                    send_item(item(nbos_pkg::MODE_NONE, $urandom, 2'($urandom),
                                   180'({6{$urandom}})));
            end
            drain();
        end

        $display("Covered %0d loads (%0d full, %0d skipped) and %0d queries,",
                 board.loads, board.fulls, board.skips, board.queries);
        $display("of which %0d found an owner and %0d were inside it.",
                 board.owned, board.inside_hits);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
